[sv/md5_stream_hasher_core_defines.svh]
// Shared assertion macros for the MD5 stream hasher
`ifndef MD5_STREAM_HASHER_CORE_DEFINES_SVH
`define MD5_STREAM_HASHER_CORE_DEFINES_SVH
// Assert an implication on every clock edge outside reset
`define MD5_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("md5 check failed");
// Assert an implication whose consequent holds in the next cycle
`define MD5_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("md5 check failed");
`endif

[sv/md5sh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5sh_pkg
// Constants and round tables for the MD5 stream hasher.
// ----------------------------------------------------------------------------
package md5sh_pkg;
  typedef logic [31:0] word_t;

  localparam word_t IV_A = 32'h67452301;
  localparam word_t IV_B = 32'hefcdab89;
  localparam word_t IV_C = 32'h98badcfe;
  localparam word_t IV_D = 32'h10325476;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic word_t sine_k(input logic [5:0] j);
    word_t rom [64];
    rom = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    return rom[j];
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] j);
    logic [4:0] r;
    case ({j[5:4], j[1:0]})
      4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
      4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
      4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
      4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
    endcase
    return r;
  endfunction

  // message word index per round
  function automatic logic [3:0] msg_idx(input logic [5:0] j);
    logic [3:0] jl;
    jl = j[3:0];
    case (j[5:4])
      2'd0: return jl;
      2'd1: return 4'((jl << 2) + jl + 4'd1);
      2'd2: return 4'((jl << 1) + jl + 4'd5);
      default: return 4'((jl << 3) - jl);
    endcase
  endfunction

  function automatic word_t bswap(input word_t v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction
endpackage

[sv/md5sh_round.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5sh_round
// One MD5 round step: the shared unit the sequencer runs 64 times a block.
// ----------------------------------------------------------------------------
module md5sh_round (
  input  logic [5:0]       round,
  input  md5sh_pkg::word_t a,
  input  md5sh_pkg::word_t b,
  input  md5sh_pkg::word_t c,
  input  md5sh_pkg::word_t d,
  input  md5sh_pkg::word_t m,
  output md5sh_pkg::word_t b_new
);
  md5sh_pkg::word_t f, t;
  logic [4:0] s;
  always_comb begin
    case (round[5:4])
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (d & b) | (~d & c);
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    t = f + a + md5sh_pkg::sine_k(round) + m;
    s = md5sh_pkg::rot_amt(round);
    b_new = b + ((t << s) | (t >> (6'd32 - {1'b0, s})));
  end
endmodule

[sv/md5_stream_hasher_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_stream_hasher_core
// MD5 digest of a byte stream, one round per cycle on a shared round unit.
// ----------------------------------------------------------------------------
// channel | dir | tdata                  | tuser          | tlast
// in      | in  | [7:0] data_byte        | byte_present   | end_of_message
// out     | out | [31:0] digest_word     | [1:0] word_index | last_word
//
// A byte that does not fill a block is stored and ready stays high. A byte
// that fills the block runs 64 rounds plus chain update before ready returns.
// End of message takes one or two compressions plus pad fill, then four output words.
// Ready drops while padding, while the round unit runs or updates the chain, or while digest words wait.
// Synchronous active-low reset clears control and loads the initial chaining
// words; the block buffer is not reset.
module md5_stream_hasher_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // byte_present
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [1:0]  out_tuser,  // [1:0] word_index
  output logic        out_tlast   // last_word
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;  // write pad bytes one per cycle
  localparam logic [2:0] ST_RND  = 3'd2;
  localparam logic [2:0] ST_ADD  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [31:0] blk_r [16];
  md5sh_pkg::word_t h_r [4];
  md5sh_pkg::word_t a_r, b_r, c_r, d_r;
  logic [5:0] fill_r, rnd_r;
  logic [60:0] total_r;
  logic fin_r;        // closing message
  logic lenblk_r;     // current compression is the final length block
  logic padded_r;     // 0x80 marker already written for this message
  logic [1:0] oidx_r;
  md5sh_pkg::word_t m_w, bnew_w;
  logic [63:0] bits_w;

  assign in_tready = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata = md5sh_pkg::bswap(h_r[oidx_r]);
  assign out_tuser = oidx_r;
  assign out_tlast = (oidx_r == 2'd3);
  assign bits_w = {total_r, 3'b000};

  // fetch message word for this round; length words override in last block
  always_comb begin
    logic [3:0] g;
    g = md5sh_pkg::msg_idx(rnd_r);
    m_w = blk_r[g];
    if (lenblk_r && g == 4'd14) m_w = bits_w[31:0];
    if (lenblk_r && g == 4'd15) m_w = bits_w[63:32];
  end

  md5sh_round u_round (
    .round(rnd_r), .a(a_r), .b(b_r), .c(c_r), .d(d_r), .m(m_w), .b_new(bnew_w)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_tvalid) begin
        // a byte that completes the block compresses first
        if (in_tuser && fill_r == 6'd63) state_nxt = ST_RND;
        else if (in_tlast) state_nxt = ST_PAD;
      end
      // block ends at the length slot or at the last byte
      ST_PAD: if (fill_r == 6'd55 || fill_r == 6'd63) state_nxt = ST_RND;
      ST_RND: if (rnd_r == 6'd63) state_nxt = ST_ADD;
      ST_ADD: begin
        if (!fin_r) state_nxt = ST_IDLE;
        else if (lenblk_r) state_nxt = ST_OUT;
        else state_nxt = ST_PAD;
      end
      ST_OUT: if (out_tready && oidx_r == 2'd3) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    logic [5:0] fp;
    fp = fill_r + 6'd1;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      h_r[0] <= md5sh_pkg::IV_A; h_r[1] <= md5sh_pkg::IV_B;
      h_r[2] <= md5sh_pkg::IV_C; h_r[3] <= md5sh_pkg::IV_D;
      fill_r <= '0; total_r <= '0; rnd_r <= '0;
      fin_r <= 1'b0; lenblk_r <= 1'b0; padded_r <= 1'b0; oidx_r <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: if (in_tvalid) begin
          fin_r <= in_tlast;
          lenblk_r <= 1'b0;
          padded_r <= 1'b0;
          if (in_tuser) begin
            blk_r[fill_r[5:2]][fill_r[1:0]*8 +: 8] <= in_tdata;
            total_r <= total_r + 61'd1;
            fill_r <= fp;
          end
          rnd_r <= '0;
          {a_r, b_r, c_r, d_r} <= {h_r[0], h_r[1], h_r[2], h_r[3]};
        end
        ST_PAD: begin
          // first pad byte is 0x80, the rest are zero
          blk_r[fill_r[5:2]][fill_r[1:0]*8 +: 8] <=
            padded_r ? 8'h00 : md5sh_pkg::PAD_BYTE;
          padded_r <= 1'b1;
          if (fill_r == 6'd55 || fill_r == 6'd63) begin
            // length fits only when padding stopped at the length slot
            lenblk_r <= (fill_r == 6'd55);
            fill_r <= '0;
          end else begin
            fill_r <= fp;
          end
          rnd_r <= '0;
          {a_r, b_r, c_r, d_r} <= {h_r[0], h_r[1], h_r[2], h_r[3]};
        end
        ST_RND: begin
          a_r <= d_r; d_r <= c_r; c_r <= b_r; b_r <= bnew_w;
          rnd_r <= rnd_r + 6'd1;
        end
        ST_ADD: begin
          h_r[0] <= h_r[0] + a_r; h_r[1] <= h_r[1] + b_r;
          h_r[2] <= h_r[2] + c_r; h_r[3] <= h_r[3] + d_r;
          oidx_r <= '0;
          // no room for the length: pad a fresh length block next
          if (fin_r && !lenblk_r) fill_r <= '0;
        end
        ST_OUT: if (out_tready) begin
          oidx_r <= oidx_r + 2'd1;
          if (oidx_r == 2'd3) begin
            h_r[0] <= md5sh_pkg::IV_A; h_r[1] <= md5sh_pkg::IV_B;
            h_r[2] <= md5sh_pkg::IV_C; h_r[3] <= md5sh_pkg::IV_D;
            fill_r <= '0; total_r <= '0; fin_r <= 1'b0; lenblk_r <= 1'b0;
            padded_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

[sv/md5sh_checker.sv]
`timescale 1ns / 1ps
`include "md5_stream_hasher_core_defines.svh"
// ----------------------------------------------------------------------------
// md5sh_checker
// Port-level checks on the MD5 stream hasher, bound to the top level.
// ----------------------------------------------------------------------------
module md5sh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);
  `MD5_ASSERT_IMPL(a_no_overlap, out_tvalid, !in_tready)
  `MD5_ASSERT_IMPL(a_last_idx, out_tvalid, out_tlast == (out_tuser == 2'd3))
  `MD5_ASSERT_NEXT(a_idx_step, out_tvalid && out_tready && !out_tlast,
    out_tvalid && out_tuser == $past(out_tuser) + 2'd1)
  `MD5_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, $stable(out_tdata))
endmodule

bind md5_stream_hasher_core md5sh_checker u_md5sh_checker (.*);

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream test of the MD5 hasher: random and directed messages are fed in,
// an internal MD5 predictor computes the digest words, and a scoreboard
// checks each output word in order, under random idling on both sides.
// ----------------------------------------------------------------------------

class digest_scoreboard;
  logic [34:0] pending_words[$];
  int          err_count;
  logic [31:0] chain[4];
  logic [31:0] blk[16];
  logic [5:0]  fill;
  logic [60:0] total;

  function new();
    err_count = 0;
    clear_message();
    foreach (blk[i]) blk[i] = '0;
  endfunction

  function void clear_message();
    chain[0] = md5sh_pkg::IV_A;
    chain[1] = md5sh_pkg::IV_B;
    chain[2] = md5sh_pkg::IV_C;
    chain[3] = md5sh_pkg::IV_D;
    fill = '0;
    total = '0;
  endfunction

  function logic [31:0] rol(logic [31:0] v, int n);
    return (n == 0) ? v : ((v << n) | (v >> (32 - n)));
  endfunction

  function void compress();
    logic [31:0] a, b, c, d, f, t;
    int g, sh;
    int rots[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    logic [31:0] k[64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int j = 0; j < 64; j++) begin
      if (j < 16) begin
        f = (b & c) | (~b & d); g = j;
      end else if (j < 32) begin
        f = (d & b) | (~d & c); g = (5 * j + 1) % 16;
      end else if (j < 48) begin
        f = b ^ c ^ d; g = (3 * j + 5) % 16;
      end else begin
        f = c ^ (b | ~d); g = (7 * j) % 16;
      end
      t = f + a + k[j] + blk[g];
      sh = rots[((j >> 4) << 2) | (j & 3)];
      a = d; d = c; c = b;
      b = b + rol(t, sh);
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endfunction

  function void put(int pos, logic [7:0] v);
    blk[pos >> 2][(pos & 3) * 8 +: 8] = v;
  endfunction

  // note an accepted input word and queue any digest words it produces
  function void note_input(logic [7:0] data, logic present, logic eom);
    logic [63:0] bits;
    int pos;
    if (present) begin
      put(fill, data);
      total = total + 61'd1;
      fill = fill + 6'd1;
      if (fill == 0) compress();
    end
    if (!eom) return;
    pos = fill;
    put(pos, md5sh_pkg::PAD_BYTE);
    for (int i = pos + 1; i < 64; i++) put(i, 8'h00);
    if (pos > 55) begin
      compress();
      foreach (blk[i]) blk[i] = '0;
    end
    bits = {total, 3'b000};
    blk[14] = bits[31:0];
    blk[15] = bits[63:32];
    compress();
    for (int w = 0; w < 4; w++) begin
      pending_words.push_back({w == 3, 2'(w),
        {chain[w][7:0], chain[w][15:8], chain[w][23:16], chain[w][31:24]}});
    end
    clear_message();
  endfunction

  function void report(string msg);
    $display("MISMATCH: %s", msg);
    err_count++;
  endfunction

  function void check_word(logic [31:0] dw, logic [1:0] idx, logic lst);
    logic [34:0] e;
    if (pending_words.size() == 0) begin
      report($sformatf("unexpected word %h idx %0d", dw, idx));
      return;
    end
    e = pending_words.pop_front();
    if (dw !== e[31:0]) report($sformatf("digest %h exp %h", dw, e[31:0]));
    if (idx !== e[33:32]) report($sformatf("index %0d exp %0d", idx, e[33:32]));
    if (lst !== e[34]) report($sformatf("last %b exp %b", lst, e[34]));
  endfunction
endclass

module tb_top;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  digest_scoreboard sb = new();
  bit   calm_phase = 1'b0;   // no idling on either side
  bit   hold_sink = 1'b0;    // receiver backpressure stretch
  int   quiet_cycles = 0;
  localparam int WATCHDOG = 20000;

  always #5 clk = ~clk;

  md5_stream_hasher_core DUT (.*);

  // score both channels on the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_input(in_tdata, in_tuser, in_tlast);
      if (out_tvalid && out_tready) sb.check_word(out_tdata, out_tuser, out_tlast);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // receiver: random idling, calm stretches, and one long hold-off
  always @(negedge clk) begin
    if (hold_sink) out_tready <= 1'b0;
    else if (calm_phase) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(99) >= 33);
  end

  // offer one word and hold it until it is accepted; drop valid while idling
  task automatic send_word(logic [7:0] d, logic present, logic eom);
    while (!calm_phase && $urandom_range(99) < 33) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= present;
    in_tlast  <= eom;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // send a full message of n random bytes, end flag on the last byte or alone
  task automatic send_message(int n, bit end_alone);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) send_word(8'($urandom), 1'b0, 1'b0);
      send_word(8'($urandom), 1'b1, (i == n - 1) && !end_alone);
    end
    if (end_alone || n == 0) send_word(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    int items;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty message, extreme bytes, padding boundaries
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'hff, 1'b1, 1'b1);
    send_word(8'h00, 1'b1, 1'b1);
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h62, 1'b1, 1'b0);
    send_word(8'h63, 1'b1, 1'b1);
    send_message(55, 1'b0);
    send_message(56, 1'b0);
    // long stretch with no idling on either side
    calm_phase = 1'b1;
    send_message(64, 1'b1);
    calm_phase = 1'b0;

    // pressure: stall the receiver while messages keep coming
    fork
      begin
        hold_sink = 1'b1;
        repeat (600) @(posedge clk);
        hold_sink = 1'b0;
      end
      begin
        send_message(3, 1'b0);
        send_message(1, 1'b0);
        in_tvalid <= 1'b0;
      end
    join
    @(negedge clk);

    items = 0;
    while (items < 20) begin
      int n;
      n = $urandom_range(12);
      send_message(n, $urandom_range(1));
      items += n + 1;
    end
    in_tvalid <= 1'b0;

    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.err_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

[files.f]
+incdir+sv
sv/md5sh_pkg.sv
sv/md5sh_round.sv
sv/md5_stream_hasher_core.sv
sv/md5sh_checker.sv
tb/sv/tb_top.sv
